// ===== rtl/core/ssort_pkg.sv =====
// shared types and constants for the strand sort engine
package ssort_pkg;

	localparam int MaxElements = 64;
	localparam int ValueWidth  = 32;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_PASS_START,
		ST_PASS_RD,
		ST_PASS_CMP,
		ST_MERGE_RD,
		ST_MERGE_CMP,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} ssort_state_t;

	// command bundle from controller to datapath
	typedef struct packed {
		logic load_wr;        // store an incoming word
		logic load_clr;       // end of set, clear fill count
		logic pass_start;     // first pending element starts a strand
		logic pass_rd;        // read pending element at scan index
		logic pass_step;      // classify element read last cycle
		logic merge_init;     // prepare merge pointers
		logic merge_rd;       // read strand and sorted heads
		logic merge_step;     // write one merged word
		logic copy_init;
		logic copy_rd;
		logic copy_wr;
		logic emit_init;
		logic emit_rd;
		logic emit_load;      // capture word into output register
		logic out_take;       // output register drained
	} ssort_cmd_t;

	// status bundle from datapath to controller
	typedef struct packed {
		logic scan_done;      // scan index reached remaining count
		logic left_zero;      // no pending elements remain
		logic merge_done;
		logic copy_done;
		logic emit_done;
		logic set_empty;
	} ssort_sts_t;

endpackage

// ===== rtl/core/ssort_ram.sv =====
// generic single write, single read ram with registered read
module ssort_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/core/ssort_ctrl.sv =====
// controller state machine for the strand sort engine
module ssort_ctrl
	import ssort_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_last,
	input  logic       out_full,
	input  logic       out_taken,
	input  ssort_sts_t sts,
	output logic       in_stall,
	output ssort_cmd_t cmd
);
	ssort_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		cmd.out_take = out_taken;
		case (state_q)
			ST_LOAD: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_wr = 1'b1;
					if (in_last) begin
						state_d = ST_PASS_START;
					end
				end
			end
			ST_PASS_START: begin
				if (sts.left_zero) begin
					cmd.emit_init = 1'b1;
					state_d = ST_EMIT_RD;
				end else begin
					cmd.pass_start = 1'b1;
					state_d = ST_PASS_RD;
				end
			end
			ST_PASS_RD: begin
				if (sts.scan_done) begin
					cmd.merge_init = 1'b1;
					state_d = ST_MERGE_RD;
				end else begin
					cmd.pass_rd = 1'b1;
					state_d = ST_PASS_CMP;
				end
			end
			ST_PASS_CMP: begin
				cmd.pass_step = 1'b1;
				state_d = ST_PASS_RD;
			end
			ST_MERGE_RD: begin
				if (sts.merge_done) begin
					cmd.copy_init = 1'b1;
					state_d = ST_COPY_RD;
				end else begin
					cmd.merge_rd = 1'b1;
					state_d = ST_MERGE_CMP;
				end
			end
			ST_MERGE_CMP: begin
				cmd.merge_step = 1'b1;
				state_d = ST_MERGE_RD;
			end
			ST_COPY_RD: begin
				if (sts.copy_done) begin
					state_d = ST_PASS_START;
				end else begin
					cmd.copy_rd = 1'b1;
					state_d = ST_COPY_WR;
				end
			end
			ST_COPY_WR: begin
				cmd.copy_wr = 1'b1;
				state_d = ST_COPY_RD;
			end
			ST_EMIT_RD: begin
				if (sts.emit_done) begin
					cmd.load_clr = 1'b1;
					state_d = ST_LOAD;
				end else if (!out_full || out_taken) begin
					// read only once the output register has room, read data is not held
					cmd.emit_rd = 1'b1;
					state_d = ST_EMIT_OUT;
				end
			end
			ST_EMIT_OUT: begin
				if (!out_full || out_taken) begin
					cmd.emit_load = 1'b1;
					state_d = ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	ast_stall_outside_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> in_stall)
		else $error("input taken outside load");
	ast_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_load |-> (!out_full || out_taken))
		else $error("output word overwritten");
	ast_last_leaves_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && in_valid && in_last) |=> (state_q == ST_PASS_START))
		else $error("last word did not start sorting");
endmodule

// ===== rtl/core/ssort_dp.sv =====
// datapath: stores, strand scan, merge and output register
module ssort_dp
	import ssort_pkg::*;
#(
	parameter int MaxElem = MaxElements
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ssort_cmd_t            cmd,
	input  logic [ValueWidth-1:0] in_value,
	input  logic                  in_last,
	output ssort_sts_t            sts,
	output logic                  out_full,
	output logic [ValueWidth-1:0] out_value,
	output logic                  out_end,
	output logic                  out_ovf
);
	localparam int AW = $clog2(MaxElem);
	localparam int CW = $clog2(MaxElem + 1);
	localparam logic [CW-1:0] MaxCnt = CW'(MaxElem);

	logic [CW-1:0] count_q, left_q, scan_q, keep_q, slen_q, done_q;
	logic [CW-1:0] a_q, b_q, w_q, emit_q;
	logic          ovf_q;
	logic [ValueWidth-1:0] tail_q;

	// pending store: written on load and on keep, read during scan
	logic          p_we;
	logic [AW-1:0] p_wa, p_ra;
	logic [ValueWidth-1:0] p_wd, p_rd;
	// strand store
	logic          s_we;
	logic [AW-1:0] s_wa, s_ra;
	logic [ValueWidth-1:0] s_wd, s_rd;
	// sorted store and merge buffer (merged result is built in m, copied back)
	logic          r_we;
	logic [AW-1:0] r_wa, r_ra;
	logic [ValueWidth-1:0] r_wd, r_rd;
	logic          m_we;
	logic [AW-1:0] m_wa, m_ra;
	logic [ValueWidth-1:0] m_wd, m_rd;

	logic take_strand;
	logic v_gt;

	ssort_ram #(.Width(ValueWidth), .Depth(MaxElem)) u_pend (
		.clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
	ssort_ram #(.Width(ValueWidth), .Depth(MaxElem)) u_strand (
		.clk, .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
	ssort_ram #(.Width(ValueWidth), .Depth(MaxElem)) u_sorted (
		.clk, .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(r_ra), .rdata(r_rd));
	ssort_ram #(.Width(ValueWidth), .Depth(MaxElem)) u_merge (
		.clk, .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));

	assign v_gt = $signed(p_rd) > $signed(tail_q);
	// merged from the front: take strand unless sorted head is strictly smaller
	assign take_strand = (b_q == done_q) ||
		((a_q != slen_q) && !($signed(r_rd) < $signed(s_rd)));

	always_comb begin
		p_we = 1'b0;
		p_wa = count_q[AW-1:0];
		p_wd = in_value;
		p_ra = scan_q[AW-1:0];
		if (cmd.load_wr && count_q != MaxCnt) begin
			p_we = 1'b1;
		end
		if (cmd.pass_step && !(v_gt || scan_q == CW'(1))) begin
			p_we = 1'b1;
			p_wa = keep_q[AW-1:0];
			p_wd = p_rd;
		end
		s_we = 1'b0;
		s_wa = slen_q[AW-1:0];
		s_wd = p_rd;
		s_ra = a_q[AW-1:0];
		if (cmd.pass_step && (v_gt || scan_q == CW'(1))) begin
			s_we = 1'b1;
		end
		r_ra = cmd.emit_rd ? emit_q[AW-1:0] : b_q[AW-1:0];
		r_we = cmd.copy_wr;
		r_wa = w_q[AW-1:0];
		r_wd = m_rd;
		m_ra = w_q[AW-1:0];
		m_we = cmd.merge_step;
		m_wa = w_q[AW-1:0];
		m_wd = take_strand ? s_rd : r_rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ovf_q    <= 1'b0;
			left_q   <= '0;
			scan_q   <= '0;
			keep_q   <= '0;
			slen_q   <= '0;
			done_q   <= '0;
			a_q      <= '0;
			b_q      <= '0;
			w_q      <= '0;
			emit_q   <= '0;
			out_full <= 1'b0;
		end else begin
			if (cmd.load_wr) begin
				if (count_q != MaxCnt) begin
					count_q <= count_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
				if (in_last) begin
					left_q <= (count_q != MaxCnt) ? count_q + CW'(1) : count_q;
					done_q <= '0;
				end
			end
			if (cmd.pass_start) begin
				scan_q <= '0;
				keep_q <= '0;
				slen_q <= '0;
			end
			if (cmd.pass_rd) begin
				scan_q <= scan_q + CW'(1);
			end
			if (cmd.pass_step) begin
				if (v_gt || scan_q == CW'(1)) begin
					tail_q <= p_rd;
					slen_q <= slen_q + CW'(1);
				end else begin
					keep_q <= keep_q + CW'(1);
				end
			end
			if (cmd.merge_init) begin
				left_q <= keep_q;
				a_q <= '0;
				b_q <= '0;
				w_q <= '0;
			end
			if (cmd.merge_step) begin
				w_q <= w_q + CW'(1);
				if (take_strand) begin
					a_q <= a_q + CW'(1);
				end else begin
					b_q <= b_q + CW'(1);
				end
			end
			if (cmd.copy_init) begin
				done_q <= done_q + slen_q;
				w_q <= '0;
			end
			if (cmd.copy_wr) begin
				w_q <= w_q + CW'(1);
			end
			if (cmd.emit_init) begin
				emit_q <= '0;
			end
			if (cmd.emit_rd) begin
				emit_q <= emit_q + CW'(1);
			end
			if (cmd.emit_load) begin
				out_full <= 1'b1;
			end else if (cmd.out_take) begin
				out_full <= 1'b0;
			end
			if (cmd.load_clr) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			out_value <= r_rd;
			out_end   <= (emit_q == done_q);
			out_ovf   <= ovf_q;
		end
	end

	always_comb begin
		sts.scan_done  = (scan_q == left_q);
		sts.left_zero  = (left_q == '0);
		sts.merge_done = (w_q == slen_q + done_q);
		sts.copy_done  = (w_q == done_q);
		sts.emit_done  = (emit_q == done_q);
		sts.set_empty  = (count_q == '0);
	end

	ast_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MaxCnt)
		else $error("fill count beyond depth");
	ast_merge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.merge_step |-> (a_q <= slen_q && b_q <= done_q))
		else $error("merge pointer overran");
	ast_keep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pass_step |-> (keep_q < scan_q))
		else $error("kept more than scanned");
endmodule

// ===== rtl/core/strand_sort_engine.sv =====
// top level of the strand sort engine
//  channel | signals                                  | direction
//  input   | valid, stall, value, last                | in
//  output  | out_valid, out_stall, sorted_value,      | out
//          | end_of_set, overflow                     |
// words are stored one per cycle until the word marked last; the set is then sorted.
// each strand pass reads every remaining element once, each merge reads the strand and sorted
// heads for each merged element and copies the merged result back into the sorted store,
// limited by the single read port of each store; emission reads one sorted word at a time.
// input is stalled from the last word until the final sorted word is in the output register.
// reset clears all control state; store contents are undefined until written.
module strand_sort_engine
	import ssort_pkg::*;
#(
	parameter int MaxElem = MaxElements
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid,
	output logic                  stall,
	input  logic [ValueWidth-1:0] value,
	input  logic                  last,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [ValueWidth-1:0] sorted_value,
	output logic                  end_of_set,
	output logic                  overflow
);
	ssort_cmd_t cmd;
	ssort_sts_t sts;
	logic       out_full;

	ssort_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(valid),
		.in_last(last),
		.out_full,
		.out_taken(out_full && !out_stall),
		.sts,
		.in_stall(stall),
		.cmd
	);

	ssort_dp #(.MaxElem(MaxElem)) u_dp (
		.clk, .arst_n,
		.cmd,
		.in_value(value),
		.in_last(last),
		.sts,
		.out_full,
		.out_value(sorted_value),
		.out_end(end_of_set),
		.out_ovf(overflow)
	);

	assign out_valid = out_full;
endmodule
